// ===== design/oef_pkg.sv =====
// types, constants and codes shared by the one euro filter and its checker
package oef_pkg;

   // item field widths
   localparam int VALUE_WIDTH = 32;
   localparam int TIME_WIDTH  = 20;

   // internal widths
   localparam int RATE_WIDTH   = 48;
   localparam int MAG_WIDTH    = RATE_WIDTH + 1;
   localparam int BLEND_WIDTH  = MAG_WIDTH + 1;
   localparam int MUL_WIDTH    = 32;
   localparam int PROD_WIDTH   = 2 * MUL_WIDTH;
   localparam int REM_WIDTH    = 64;
   localparam int CUT_WIDTH    = 32;
   localparam int CNT_WIDTH    = 6;
   localparam int DT_WIDTH     = (TIME_WIDTH > 14) ? TIME_WIDTH : 14;
   localparam int NUM_WIDTH    = (VALUE_WIDTH + 20 > MAG_WIDTH) ? VALUE_WIDTH + 20 : MAG_WIDTH;
   localparam int NUM_HI_WIDTH = NUM_WIDTH - RATE_WIDTH;

   // configuration registers
   localparam int BASE_CUT_WIDTH     = 16;
   localparam int SPEED_GAIN_WIDTH   = 24;
   localparam int DERIV_CUTOFF_WIDTH = 16;
   localparam int CSR_DATA_WIDTH     = 24;
   localparam int CSR_INDEX_WIDTH    = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BASE_CUT     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPEED_GAIN   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DERIV_CUTOFF = 2'd2;

   localparam logic [BASE_CUT_WIDTH-1:0]     BASE_CUT_RESET     = 16'd256;
   localparam logic [SPEED_GAIN_WIDTH-1:0]   SPEED_GAIN_RESET   = 24'd0;
   localparam logic [DERIV_CUTOFF_WIDTH-1:0] DERIV_CUTOFF_RESET = 16'd256;

   // arithmetic constants
   localparam logic [13:0]           ZERO_DT_US     = 14'd11111;
   localparam logic [MUL_WIDTH-1:0]  US_PER_SECOND  = 32'd1000000;
   localparam logic [REM_WIDTH-1:0]  GAIN_K         = 64'd10430378350;
   localparam logic [PROD_WIDTH-1:0] PRODUCT_CAP    = 64'h003F_FFFF_FFFF_FFFF;
   localparam logic [RATE_WIDTH-1:0] RATE_POS_LIMIT = 48'h7FFF_FFFF_FFFF;
   localparam logic [RATE_WIDTH-1:0] RATE_NEG_LIMIT = 48'h8000_0000_0000;
   localparam logic [CUT_WIDTH-1:0]  CUTOFF_MAX     = 32'hFFFF_FFFF;
   localparam logic [31:0]           ROUND_HALF     = 32'h8000_0000;

   localparam logic [CNT_WIDTH-1:0] RATE_DIV_LAST = 6'd47;
   localparam logic [CNT_WIDTH-1:0] GAIN_DIV_LAST = 6'd31;

   // item modes
   localparam logic MODE_FILTER = 1'b0;
   localparam logic MODE_CLEAR  = 1'b1;

   typedef struct packed {
      logic                          mode;
      logic signed [VALUE_WIDTH-1:0] sample;
      logic [TIME_WIDTH-1:0]         elapsed_us;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] smoothed;
      logic                          primed;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DIFF,
      ST_RATE_MUL_LO,
      ST_RATE_MUL_HI,
      ST_RATE_SUM,
      ST_RATE_SETUP,
      ST_RATE_DIV,
      ST_RATE_SAT,
      ST_GAIN_MUL,
      ST_GAIN_SETUP,
      ST_GAIN_DIV,
      ST_BLEND_DIFF,
      ST_BLEND_MUL_LO,
      ST_BLEND_MUL_HI,
      ST_BLEND_SUM,
      ST_CUT_MUL_LO,
      ST_CUT_MUL_HI,
      ST_CUT_SUM,
      ST_WRITE
   } state_type;

   // which quantity the shared blend and gain steps work on
   typedef enum logic {
      PH_RATE,
      PH_VALUE
   } phase_type;

endpackage

// ===== design/one_euro_filter.sv =====
// one euro filter: adaptive low-pass filter over one signed q16.16 sample stream
//
// req channel: one item per sample (mode, sample, elapsed_us), valid/stall handshake.
//   mode clear drops the filter state so the next sample primes; it gives no result
//   and the block is ready again in the next cycle.
// rsp channel: one item (smoothed, primed) for each mode filter item, valid/stall.
// csr port: csr_write with csr_index 0 base cutoff, 1 speed_gain, 2 derivative_cutoff;
//   other indexes are ignored. write only while the block is idle.
// sequence: a priming sample goes straight to the write state; a filtered sample runs
//   the whole sequence, and no new item is taken until it is done. the cost is set by
//   the shared shift-subtract divide step (48 steps for the raw derivative, 32 steps
//   for each of the two gains) plus the shared 32x32 multiplier passes.
// req_stall is high whenever the sequencer is not idle. the result register lets the
//   next item be accepted while a finished result waits; if rsp is still stalled when
//   the next result is ready, the sequencer waits in its write state.
// reset (synchronous, active high) clears the sequencer, the result valid flag, the
//   started flag and restores the configuration register defaults.
module one_euro_filter
   import oef_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  req_type                       req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rsp_type                       rsp_data,
   input  logic                          csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_wdata
);

   // control state
   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      started_ff, started_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // configuration
   logic [BASE_CUT_WIDTH-1:0]     base_cut_ff;
   logic [SPEED_GAIN_WIDTH-1:0]   speed_gain_ff;
   logic [DERIV_CUTOFF_WIDTH-1:0] deriv_cutoff_ff;

   // filter state and working registers
   logic signed [VALUE_WIDTH-1:0] last_value_ff, last_value_in;
   logic signed [RATE_WIDTH-1:0]  last_rate_ff, last_rate_in;
   logic signed [RATE_WIDTH-1:0]  raw_rate_ff, raw_rate_in;
   logic signed [VALUE_WIDTH-1:0] x_ff, x_in;
   logic [DT_WIDTH-1:0]           t_ff, t_in;
   logic                          primed_ff, primed_in;
   logic [MAG_WIDTH-1:0]          mag_ff, mag_in;
   logic                          neg_ff, neg_in;
   logic [PROD_WIDTH-1:0]         prod_ff, prod_in;
   logic [31:0]                   acc_ff, acc_in;
   logic [NUM_WIDTH-1:0]          num_ff, num_in;
   logic [REM_WIDTH-1:0]          rem_ff, rem_in;
   logic [REM_WIDTH-1:0]          div_ff, div_in;
   logic [RATE_WIDTH-1:0]         quo_ff, quo_in;
   logic [CNT_WIDTH-1:0]          cnt_ff, cnt_in;
   logic                          ovf_ff, ovf_in;
   logic [CUT_WIDTH-1:0]          cutoff_ff, cutoff_in;
   rsp_type                       rsp_data_ff, rsp_data_in;

   // shared units
   logic [MUL_WIDTH-1:0]          mul_a, mul_b;
   logic [REM_WIDTH-1:0]          trial;
   logic                          trial_ge;
   logic signed [BLEND_WIDTH-1:0] cur_ext, prev_ext, bl_diff;
   logic [BLEND_WIDTH-1:0]        bl_abs, bl_step, bl_res;
   logic [RATE_WIDTH-1:0]         rate_abs, rate_limit, rate_mag;
   logic [DT_WIDTH-1:0]           t_sample;
   logic                          req_fire, out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a zero elapsed time stands for 1/90 s
   assign t_sample = (req_data.elapsed_us == '0) ? DT_WIDTH'(ZERO_DT_US)
                                                 : DT_WIDTH'(req_data.elapsed_us);

   // shift-subtract divide step: remainder and numerator/quotient shift together
   assign trial    = {rem_ff[REM_WIDTH-2:0], quo_ff[RATE_WIDTH-1]};
   assign trial_ge = (trial >= div_ff);

   // blend operands: derivative phase works on the rate, value phase on the sample
   assign cur_ext  = (phase_ff == PH_VALUE) ? BLEND_WIDTH'(x_ff) : BLEND_WIDTH'(raw_rate_ff);
   assign prev_ext = (phase_ff == PH_VALUE) ? BLEND_WIDTH'(last_value_ff)
                                            : BLEND_WIDTH'(last_rate_ff);
   assign bl_diff  = cur_ext - prev_ext;
   assign bl_abs   = bl_diff[BLEND_WIDTH-1] ? BLEND_WIDTH'(-bl_diff) : BLEND_WIDTH'(bl_diff);
   assign bl_step  = BLEND_WIDTH'(prod_ff) + BLEND_WIDTH'(acc_ff);
   assign bl_res   = neg_ff ? BLEND_WIDTH'(prev_ext) - bl_step
                            : BLEND_WIDTH'(prev_ext) + bl_step;

   // |rate| for the cutoff, at most 2^47
   assign rate_abs = last_rate_ff[RATE_WIDTH-1] ? RATE_WIDTH'(-last_rate_ff)
                                                : RATE_WIDTH'(last_rate_ff);

   // raw derivative saturation, negative side reaches one further
   assign rate_limit = neg_ff ? RATE_NEG_LIMIT : RATE_POS_LIMIT;
   assign rate_mag   = (ovf_ff || (quo_ff > rate_limit)) ? rate_limit : quo_ff;

   // registered 32x32 multiplier
   assign prod_in = {{(PROD_WIDTH-MUL_WIDTH){1'b0}}, mul_a}
                  * {{(PROD_WIDTH-MUL_WIDTH){1'b0}}, mul_b};

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_data.mode == MODE_FILTER)) begin
               state_in = started_ff ? ST_DIFF : ST_WRITE;
            end
         end
         ST_DIFF:         state_in = ST_RATE_MUL_LO;
         ST_RATE_MUL_LO:  state_in = ST_RATE_MUL_HI;
         ST_RATE_MUL_HI:  state_in = ST_RATE_SUM;
         ST_RATE_SUM:     state_in = ST_RATE_SETUP;
         ST_RATE_SETUP:   state_in = ST_RATE_DIV;
         ST_RATE_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_RATE_SAT;
            end
         end
         ST_RATE_SAT:     state_in = ST_GAIN_MUL;
         ST_GAIN_MUL:     state_in = ST_GAIN_SETUP;
         ST_GAIN_SETUP:   state_in = ST_GAIN_DIV;
         ST_GAIN_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_BLEND_DIFF;
            end
         end
         ST_BLEND_DIFF:   state_in = ST_BLEND_MUL_LO;
         ST_BLEND_MUL_LO: state_in = ST_BLEND_MUL_HI;
         ST_BLEND_MUL_HI: state_in = ST_BLEND_SUM;
         ST_BLEND_SUM:    state_in = (phase_ff == PH_RATE) ? ST_CUT_MUL_LO : ST_WRITE;
         ST_CUT_MUL_LO:   state_in = ST_CUT_MUL_HI;
         ST_CUT_MUL_HI:   state_in = ST_CUT_SUM;
         ST_CUT_SUM:      state_in = ST_GAIN_MUL;
         ST_WRITE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:         state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs per sequencer step
   always_comb begin
      phase_in      = phase_ff;
      started_in    = started_ff;
      last_value_in = last_value_ff;
      last_rate_in  = last_rate_ff;
      raw_rate_in   = raw_rate_ff;
      x_in          = x_ff;
      t_in          = t_ff;
      primed_in     = primed_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      acc_in        = acc_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      ovf_in        = ovf_ff;
      cutoff_in     = cutoff_ff;
      rsp_data_in   = rsp_data_ff;
      mul_a         = '0;
      mul_b         = '0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.mode == MODE_CLEAR) begin
                  started_in = 1'b0;
               end else begin
                  x_in     = req_data.sample;
                  t_in     = t_sample;
                  phase_in = PH_VALUE;
                  if (!started_ff) begin
                     // first sample passes through and primes the state
                     started_in    = 1'b1;
                     primed_in     = 1'b1;
                     last_value_in = req_data.sample;
                     last_rate_in  = '0;
                  end else begin
                     primed_in = 1'b0;
                  end
               end
            end
         end
         ST_DIFF, ST_BLEND_DIFF: begin
            neg_in = bl_diff[BLEND_WIDTH-1];
            mag_in = bl_abs[MAG_WIDTH-1:0];
         end
         ST_RATE_MUL_LO: begin
            // |diff| * 1e6 in two halves
            mul_a = mag_ff[MUL_WIDTH-1:0];
            mul_b = US_PER_SECOND;
         end
         ST_RATE_MUL_HI: begin
            num_in = NUM_WIDTH'(prod_ff);
            mul_a  = MUL_WIDTH'(mag_ff[MAG_WIDTH-1:MUL_WIDTH]);
            mul_b  = US_PER_SECOND;
         end
         ST_RATE_SUM: begin
            num_in = num_ff + NUM_WIDTH'({prod_ff, 32'd0});
         end
         ST_RATE_SETUP: begin
            // upper numerator bits seed the remainder; if they reach dt the
            // quotient is past any limit
            rem_in = REM_WIDTH'(num_ff[NUM_WIDTH-1:RATE_WIDTH]);
            div_in = REM_WIDTH'(t_ff);
            quo_in = num_ff[RATE_WIDTH-1:0];
            ovf_in = (REM_WIDTH'(num_ff[NUM_WIDTH-1:RATE_WIDTH]) >= REM_WIDTH'(t_ff));
            cnt_in = RATE_DIV_LAST;
         end
         ST_RATE_DIV, ST_GAIN_DIV: begin
            rem_in = trial_ge ? trial - div_ff : trial;
            quo_in = {quo_ff[RATE_WIDTH-2:0], trial_ge};
            cnt_in = cnt_ff - 1'b1;
         end
         ST_RATE_SAT: begin
            raw_rate_in = neg_ff ? RATE_WIDTH'(-rate_mag) : rate_mag;
            phase_in    = PH_RATE;
         end
         ST_GAIN_MUL: begin
            mul_a = (phase_ff == PH_RATE) ? MUL_WIDTH'(deriv_cutoff_ff) : cutoff_ff;
            mul_b = MUL_WIDTH'(t_ff);
         end
         ST_GAIN_SETUP: begin
            // gain = floor(p * 2^32 / (p + k)), p = min(cutoff*dt, cap) * 256
            rem_in = REM_WIDTH'({((prod_ff > PRODUCT_CAP) ? PRODUCT_CAP : prod_ff), 8'd0});
            div_in = REM_WIDTH'({((prod_ff > PRODUCT_CAP) ? PRODUCT_CAP : prod_ff), 8'd0})
                     + GAIN_K;
            quo_in = '0;
            cnt_in = GAIN_DIV_LAST;
         end
         ST_BLEND_MUL_LO: begin
            mul_a = mag_ff[MUL_WIDTH-1:0];
            mul_b = quo_ff[MUL_WIDTH-1:0];
         end
         ST_BLEND_MUL_HI: begin
            // rounded low partial product
            acc_in = 32'(({1'b0, prod_ff} + {33'd0, ROUND_HALF}) >> 32);
            mul_a  = MUL_WIDTH'(mag_ff[MAG_WIDTH-1:MUL_WIDTH]);
            mul_b  = quo_ff[MUL_WIDTH-1:0];
         end
         ST_BLEND_SUM: begin
            if (phase_ff == PH_RATE) begin
               last_rate_in = bl_res[RATE_WIDTH-1:0];
            end else begin
               last_value_in = bl_res[VALUE_WIDTH-1:0];
            end
         end
         ST_CUT_MUL_LO: begin
            mul_a = MUL_WIDTH'(speed_gain_ff);
            mul_b = MUL_WIDTH'(rate_abs[23:0]);
         end
         ST_CUT_MUL_HI: begin
            acc_in = 32'(prod_ff >> 24);
            mul_a  = MUL_WIDTH'(speed_gain_ff);
            mul_b  = MUL_WIDTH'(rate_abs[RATE_WIDTH-1:24]);
         end
         ST_CUT_SUM: begin
            if ((BLEND_WIDTH'(prod_ff) + BLEND_WIDTH'(acc_ff) + BLEND_WIDTH'(base_cut_ff))
                > BLEND_WIDTH'(CUTOFF_MAX)) begin
               cutoff_in = CUTOFF_MAX;
            end else begin
               cutoff_in = CUT_WIDTH'(BLEND_WIDTH'(prod_ff) + BLEND_WIDTH'(acc_ff)
                                      + BLEND_WIDTH'(base_cut_ff));
            end
            phase_in = PH_VALUE;
         end
         ST_WRITE: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.smoothed = last_value_ff;
               rsp_data_in.primed   = primed_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         phase_ff        <= PH_VALUE;
         started_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         base_cut_ff     <= BASE_CUT_RESET;
         speed_gain_ff   <= SPEED_GAIN_RESET;
         deriv_cutoff_ff <= DERIV_CUTOFF_RESET;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               CSR_BASE_CUT:     base_cut_ff     <= csr_wdata[BASE_CUT_WIDTH-1:0];
               CSR_SPEED_GAIN:   speed_gain_ff   <= csr_wdata[SPEED_GAIN_WIDTH-1:0];
               CSR_DERIV_CUTOFF: deriv_cutoff_ff <= csr_wdata[DERIV_CUTOFF_WIDTH-1:0];
               default: begin
                  // unused index, write dropped
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      last_value_ff <= last_value_in;
      last_rate_ff  <= last_rate_in;
      raw_rate_ff   <= raw_rate_in;
      x_ff          <= x_in;
      t_ff          <= t_in;
      primed_ff     <= primed_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      ovf_ff        <= ovf_in;
      cutoff_ff     <= cutoff_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

// ===== design/oef_checker.sv =====
// port-level checks for the one euro filter, bound to the top level
module oef_checker
   import oef_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input req_type                    req_data,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input rsp_type                    rsp_data
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // reset leaves the block ready with no result pending
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // a clear item gives no result and leaves the block ready
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.mode == MODE_CLEAR) |=> !req_stall)
      else $error("clear item made the block busy");

   // a sample item keeps the block busy until its result is written
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.mode == MODE_FILTER) |=> req_stall)
      else $error("sample item did not start work");

   // a new result only comes out of a busy block
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without work");

endmodule

bind one_euro_filter oef_checker u_oef_checker (.*);

// ===== test/one_euro_filter_tb.sv =====
// self-checking testbench for one_euro_filter: directed table, then random sample tracks
module one_euro_filter_tb;
   import oef_pkg::*;

   // generous ceiling: ~470 items at worst-case item cost, several times over
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned MAX_REPORTS = 10;
   localparam int unsigned PHASES      = 8;
   localparam int unsigned PHASE_ITEMS = 50;
   localparam int unsigned DRAIN_WAIT  = 150;
   localparam int unsigned DIRECTED_ROWS = 22;
   // the one index the register file leaves unused
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;
   localparam rsp_type NO_RSP = '0;

   // one directed row: the item, and a typed-in result where it is obvious
   typedef struct packed {
      req_type req;
      bit      typed;
      rsp_type want;
   } step_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic                       csr_write = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // shadow of the filter: registers at their reset values, state cleared
   logic [BASE_CUT_WIDTH-1:0]     m_base_cut   = BASE_CUT_RESET;
   logic [SPEED_GAIN_WIDTH-1:0]   m_speed_gain = SPEED_GAIN_RESET;
   logic [DERIV_CUTOFF_WIDTH-1:0] m_deriv_cut  = DERIV_CUTOFF_RESET;
   bit     m_started = 1'b0;
   longint m_value   = 0;
   longint m_rate    = 0;

   rsp_type      smoothed_due[$];
   int unsigned  fault_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  stall_left  = 0;
   // set for stretches where neither side idles
   bit           steady      = 1'b0;
   step_row_type directed [DIRECTED_ROWS];
   int unsigned  phase;

   one_euro_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // q0.32 smoothing gain r/(1+r), r = 2*pi*cutoff*dt, by restoring division
   function automatic logic [31:0] gain_q32(input longint unsigned cut,
                                            input longint unsigned dt);
      longint unsigned scaled, den, acc, quo;
      int i;
      scaled = cut * dt;
      if (scaled > PRODUCT_CAP) scaled = PRODUCT_CAP;
      scaled = scaled << 8;
      den = scaled + GAIN_K;
      acc = scaled;
      quo = 0;
      for (i = 0; i < 32; i++) begin
         acc = acc << 1;
         quo = quo << 1;
         if (acc >= den) begin
            acc = acc - den;
            quo = quo | 64'd1;
         end
      end
      return quo[31:0];
   endfunction

   // round(mag * g / 2^32), ties away from zero
   function automatic longint unsigned gain_scale(input longint unsigned mag,
                                                  input logic [31:0] g);
      return (mag >> 32) * 64'(g)
           + (((mag & 64'hFFFF_FFFF) * 64'(g) + 64'(ROUND_HALF)) >> 32);
   endfunction

   // step from prev toward cur by gain g; sign handled on the magnitude
   function automatic longint blend_toward(input longint cur, input longint prev,
                                           input logic [31:0] g);
      longint d;
      d = cur - prev;
      if (d < 0) return prev - longint'(gain_scale(64'(-d), g));
      return prev + longint'(gain_scale(64'(d), g));
   endfunction

   // diff per second, magnitude truncated, saturated to the 48-bit rate range
   function automatic longint rate_of(input longint diff, input longint unsigned dt);
      bit neg;
      longint unsigned mag, cap, whole, q;
      neg = diff < 0;
      mag = neg ? 64'(-diff) : 64'(diff);
      cap = (64'd1 << (RATE_WIDTH - 1)) - (neg ? 64'd0 : 64'd1);
      whole = mag / dt;
      if (whole > cap / 64'(US_PER_SECOND)) begin
         q = cap;
      end else begin
         q = whole * 64'(US_PER_SECOND) + ((mag % dt) * 64'(US_PER_SECOND)) / dt;
         if (q > cap) q = cap;
      end
      return neg ? -longint'(q) : longint'(q);
   endfunction

   // advances the shadow state by one item; returns 1 when a result is due
   function automatic bit predict_smoothed(input req_type item, output rsp_type r);
      longint x, rate, est;
      longint unsigned dt, mag, cut, part_hi, part_lo;
      r = '0;
      if (item.mode == MODE_CLEAR) begin
         m_started = 1'b0;
         return 1'b0;
      end
      x  = longint'($signed(item.sample));
      dt = 64'(item.elapsed_us);
      if (dt == 0) dt = 64'(ZERO_DT_US);
      // first sample after reset or clear passes through
      if (!m_started) begin
         m_started  = 1'b1;
         m_value    = x;
         m_rate     = 0;
         r.smoothed = item.sample;
         r.primed   = 1'b1;
         return 1'b1;
      end
      rate = blend_toward(rate_of(x - m_value, dt), m_rate, gain_q32(64'(m_deriv_cut), dt));
      mag  = (rate < 0) ? 64'(-rate) : 64'(rate);
      // cutoff = base cutoff + beta*|rate|, split so the product stays in 64 bits
      part_hi = 64'(m_speed_gain) * (mag >> 24);
      part_lo = (64'(m_speed_gain) * (mag & 64'hFF_FFFF)) >> 24;
      cut = part_hi + part_lo + 64'(m_base_cut);
      if (cut > 64'(CUTOFF_MAX)) cut = 64'(CUTOFF_MAX);
      est = blend_toward(x, m_value, gain_q32(cut, dt));
      m_value    = est;
      m_rate     = rate;
      r.smoothed = est[VALUE_WIDTH-1:0];
      r.primed   = 1'b0;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- sender

   // random gap, then hold the item until it is taken; the shadow runs on acceptance
   task automatic offer(input req_type item, input bit typed = 1'b0,
                        input rsp_type want = '0);
      int unsigned gap;
      rsp_type due;
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      if (predict_smoothed(item, due))
         smoothed_due.insert(smoothed_due.size(), typed ? want : due);
   endtask

   // stop sending and wait until every result is back and the block is idle
   task automatic settle();
      req_valid <= 1'b0;
      while (smoothed_due.size() != 0) @(posedge clock);
      // a trailing clear item gives no result to wait on
      repeat (4) @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_BASE_CUT:     m_base_cut   = value[BASE_CUT_WIDTH-1:0];
         CSR_SPEED_GAIN:   m_speed_gain = value[SPEED_GAIN_WIDTH-1:0];
         CSR_DERIV_CUTOFF: m_deriv_cut  = value[DERIV_CUTOFF_WIDTH-1:0];
         default: ;
      endcase
   endtask

   // mostly tracks: clear, priming sample, then a random walk of filtered samples;
   // the rest is pure noise, or a track that continues without a clear
   task automatic random_items(input int unsigned count);
      int unsigned sent, run_len, i, pick;
      longint level, delta;
      req_type item;
      sent = 0;
      while (sent < count) begin
         pick   = $urandom_range(0, 9);
         steady = ($urandom_range(0, 5) == 0);
         if (pick == 0) begin
            item.mode       = 1'($urandom_range(0, 1));
            item.sample     = $urandom;
            item.elapsed_us = TIME_WIDTH'($urandom);
            offer(item);
            sent++;
         end else begin
            if (pick != 9) begin
               item.mode       = MODE_CLEAR;
               item.sample     = $urandom;
               item.elapsed_us = TIME_WIDTH'($urandom);
               offer(item);
               sent++;
            end
            level   = longint'($signed($urandom)) >>> $urandom_range(0, 16);
            // short tracks put priming results back to back
            run_len = (pick == 1) ? 1 : $urandom_range(2, 12);
            for (i = 0; i < run_len; i++) begin
               delta = longint'($signed($urandom)) >>> $urandom_range(4, 31);
               level = level + delta;
               if (level > 64'sd2147483647) level = 64'sd2147483647;
               if (level < -64'sd2147483648) level = -64'sd2147483648;
               item.mode   = MODE_FILTER;
               item.sample = level[VALUE_WIDTH-1:0];
               case ($urandom_range(0, 7))
                  0:       item.elapsed_us = '0;
                  1:       item.elapsed_us = TIME_WIDTH'($urandom);
                  2:       item.elapsed_us = TIME_WIDTH'(ZERO_DT_US);
                  3, 4:    item.elapsed_us = TIME_WIDTH'($urandom_range(5000, 40000));
                  5:       item.elapsed_us = TIME_WIDTH'($urandom_range(1, 16));
                  default: item.elapsed_us = TIME_WIDTH'($urandom_range(1, 2000));
               endcase
               offer(item);
               sent++;
            end
         end
      end
      steady = 1'b0;
   endtask

   // ---------------------------------------------------------------- receiver

   // random stall windows, started after each item and now and then while idle,
   // so they land on the cycle a result turns valid as well
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (rsp_stall) begin
         stall_left--;
         if (stall_left == 0) rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid) begin
            if (smoothed_due.size() == 0) begin
               fault_count++;
               if (fault_count <= MAX_REPORTS)
                  $display("unexpected item: smoothed %0d primed %0b",
                           rsp_data.smoothed, rsp_data.primed);
            end else if (rsp_data.smoothed !== smoothed_due[0].smoothed ||
                         rsp_data.primed !== smoothed_due[0].primed) begin
               fault_count++;
               if (fault_count <= MAX_REPORTS)
                  $display("mismatch: expected %0d primed %0b, got %0d primed %0b",
                           smoothed_due[0].smoothed, smoothed_due[0].primed,
                           rsp_data.smoothed, rsp_data.primed);
               void'(smoothed_due.pop_front());
            end else begin
               void'(smoothed_due.pop_front());
            end
         end
         if (rsp_valid || $urandom_range(0, 7) == 0) begin
            stall_left = steady ? 0 : $urandom_range(0, 6);
            if (stall_left != 0) rsp_stall <= 1'b1;
         end
      end
   end

   // hang guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      // default registers: 1 hz cutoffs, no speed gain
      directed = '{
         // first sample after reset primes
         '{'{MODE_FILTER, 32'sh0001_2345, 20'd11111}, 1'b1, '{32'sh0001_2345, 1'b1}},
         // same value again with zero dt: nothing moves
         '{'{MODE_FILTER, 32'sh0001_2345, 20'd0},     1'b1, '{32'sh0001_2345, 1'b0}},
         // full-scale jumps; the two over one microsecond saturate the derivative
         '{'{MODE_FILTER, 32'sh7FFF_FFFF, 20'd1},     1'b0, NO_RSP},
         '{'{MODE_FILTER, 32'sh8000_0000, 20'd1},     1'b0, NO_RSP},
         '{'{MODE_FILTER, 32'sh8000_0000, 20'hFFFFF}, 1'b0, NO_RSP},
         // two clears in a row, with junk in the other fields
         '{'{MODE_CLEAR,  32'sh0000_0000, 20'd0},     1'b0, NO_RSP},
         '{'{MODE_CLEAR,  32'shFFFF_FFFF, 20'hFFFFF}, 1'b0, NO_RSP},
         '{'{MODE_FILTER, 32'sh8000_0000, 20'd0},     1'b1, '{32'sh8000_0000, 1'b1}},
         '{'{MODE_FILTER, 32'sh7FFF_FFFF, 20'd0},     1'b0, NO_RSP},
         '{'{MODE_FILTER, 32'sh7FFF_FFFF, 20'd1},     1'b0, NO_RSP},
         '{'{MODE_CLEAR,  32'sh1234_5678, 20'd7},     1'b0, NO_RSP},
         '{'{MODE_FILTER, 32'sh7FFF_FFFF, 20'hFFFFF}, 1'b1, '{32'sh7FFF_FFFF, 1'b1}},
         '{'{MODE_FILTER, 32'shFFFF_FFFF, 20'd1},     1'b0, NO_RSP},
         '{'{MODE_FILTER, 32'sh0000_0000, 20'd11111}, 1'b0, NO_RSP},
         '{'{MODE_FILTER, 32'sh0000_0001, 20'd2},     1'b0, NO_RSP},
         '{'{MODE_FILTER, 32'sh0001_0000, 20'd0},     1'b0, NO_RSP},
         '{'{MODE_FILTER, 32'shFFFF_0000, 20'h80000}, 1'b0, NO_RSP},
         '{'{MODE_CLEAR,  32'sh0000_0000, 20'd0},     1'b0, NO_RSP},
         '{'{MODE_FILTER, 32'sh0000_0000, 20'd1000},  1'b1, '{32'sh0000_0000, 1'b1}},
         '{'{MODE_FILTER, 32'sh0000_0000, 20'd1000},  1'b1, '{32'sh0000_0000, 1'b0}},
         // alternating bit patterns in both fields
         '{'{MODE_FILTER, 32'sh5555_5555, 20'h55555}, 1'b0, NO_RSP},
         '{'{MODE_FILTER, 32'shAAAA_AAAA, 20'hAAAAA}, 1'b0, NO_RSP}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[k])
         offer(directed[k].req, directed[k].typed, directed[k].want);

      // each phase drains fully before the registers change
      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0: begin
               // zero cutoffs: gain is zero, the output holds the primed value
               write_reg(CSR_BASE_CUT,     '0);
               write_reg(CSR_SPEED_GAIN,   '0);
               write_reg(CSR_DERIV_CUTOFF, '0);
            end
            1: begin
               // everything at full scale, upper data bits set on the narrow ones
               write_reg(CSR_BASE_CUT,     '1);
               write_reg(CSR_SPEED_GAIN,   '1);
               write_reg(CSR_DERIV_CUTOFF, '1);
            end
            2: begin
               // the unused index must leave all registers alone
               write_reg(CSR_UNUSED,       '1);
               write_reg(CSR_BASE_CUT,     24'd256);
               write_reg(CSR_SPEED_GAIN,   24'h000400);
               write_reg(CSR_DERIV_CUTOFF, 24'd512);
            end
            3: begin
               write_reg(CSR_BASE_CUT,     24'd1);
               write_reg(CSR_SPEED_GAIN,   24'd1);
               write_reg(CSR_DERIV_CUTOFF, 24'd1);
            end
            default: begin
               write_reg(CSR_BASE_CUT,     CSR_DATA_WIDTH'($urandom));
               write_reg(CSR_SPEED_GAIN,   CSR_DATA_WIDTH'($urandom));
               write_reg(CSR_DERIV_CUTOFF, CSR_DATA_WIDTH'($urandom));
            end
         endcase
         random_items(PHASE_ITEMS);
      end

      settle();
      // catch any stray result after the last one
      repeat (DRAIN_WAIT) @(posedge clock);
      fault_count += smoothed_due.size();
      if (fault_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
